FILE: rtl/eeg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// eeg_pkg - extended Euclid gcd shared types and constants
// Widths of operands, coefficients and the beat structs of both channels.
// ---------------------------------------------------------------------------
package eeg_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OP_W       = DATA_WIDTH - 1;
    localparam int CNT_W      = $clog2(OP_W);

    typedef struct packed {
        logic [OP_W-1:0] operand_a;
        logic [OP_W-1:0] operand_b;
    } t_eeg_in;

    typedef struct packed {
        logic        [OP_W-1:0]       gcd_value;
        logic signed [DATA_WIDTH-1:0] coef_a;
        logic signed [DATA_WIDTH-1:0] coef_b;
    } t_eeg_out;

endpackage
`default_nettype wire

FILE: rtl/extended_euclid_gcd_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// extended_euclid_gcd_unit - extended Euclidean algorithm
// Gives gcd(a, b) and Bezout coefficients x, y with x*a + y*b = gcd.
// ---------------------------------------------------------------------------
// Usage: drive i_in and pulse start while busy is low. busy stays high until
// the result beat, which appears on o_result for exactly one cycle with
// o_valid high; it must be captured then, as the block cannot be stalled.
// An item runs quotient rounds until b is zero. Each round runs the
// one-bit-per-cycle restoring divider over all 31 quotient bits, then the single
// shared multiplier used once per coefficient with a subtract after each; at
// most 45 rounds for 31-bit operands. When b is zero the result is gcd = a,
// x = 1, y = 0.
module extended_euclid_gcd_unit
    import eeg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_eeg_in  i_in,
    output logic          o_valid,
    output t_eeg_out      o_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MULA  = 3'd3;
    localparam logic [2:0] ST_SUBA  = 3'd4;
    localparam logic [2:0] ST_MULB  = 3'd5;
    localparam logic [2:0] ST_SUBB  = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_valid, n_valid;
    logic [OP_W-1:0]       r_dvd, n_dvd;
    logic [OP_W-1:0]       r_dvs, n_dvs;
    logic [OP_W-1:0]       r_rem, n_rem;
    logic [OP_W-1:0]       r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_xa, n_xa, r_xan, n_xan;
    logic [DATA_WIDTH-1:0] r_xb, n_xb, r_xbn, n_xbn;
    logic [DATA_WIDTH-1:0] r_prod, n_prod;
    t_eeg_out              r_out, n_out;

    logic [OP_W:0]             w_trial;
    logic [OP_W+1:0]           w_diff;
    logic [DATA_WIDTH-1:0]     w_mul_b;
    logic [OP_W+DATA_WIDTH-1:0] w_mul;

    // restoring divider step
    assign w_trial = {r_rem, r_quo[OP_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};

    // shared multiplier, low word only
    assign w_mul_b = (r_state == ST_MULA) ? r_xan : r_xbn;
    assign w_mul   = (OP_W+DATA_WIDTH)'(r_quo) * (OP_W+DATA_WIDTH)'(w_mul_b);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_xa    = r_xa;
        n_xan   = r_xan;
        n_xb    = r_xb;
        n_xbn   = r_xbn;
        n_prod  = r_prod;
        n_out   = r_out;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_dvd   = i_in.operand_a;
                    n_dvs   = i_in.operand_b;
                    n_xa    = DATA_WIDTH'(1);
                    n_xan   = '0;
                    n_xb    = '0;
                    n_xbn   = DATA_WIDTH'(1);
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_dvs == '0) begin
                    n_out.gcd_value = r_dvd;
                    n_out.coef_a    = r_xa;
                    n_out.coef_b    = r_xb;
                    n_valid         = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_rem   = '0;
                    n_quo   = r_dvd;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!w_diff[OP_W+1]) begin
                    n_rem = w_diff[OP_W-1:0];
                end else begin
                    n_rem = w_trial[OP_W-1:0];
                end
                n_quo = {r_quo[OP_W-2:0], ~w_diff[OP_W+1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(OP_W-1)) begin
                    n_state = ST_MULA;
                end
            end
            ST_MULA: begin
                n_prod  = w_mul[DATA_WIDTH-1:0];
                n_state = ST_SUBA;
            end
            ST_SUBA: begin
                n_xa    = r_xan;
                n_xan   = r_xa - r_prod;
                n_state = ST_MULB;
            end
            ST_MULB: begin
                n_prod  = w_mul[DATA_WIDTH-1:0];
                n_state = ST_SUBB;
            end
            ST_SUBB: begin
                n_xb    = r_xbn;
                n_xbn   = r_xb - r_prod;
                n_dvd   = r_dvs;
                n_dvs   = r_rem;
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_xa   <= n_xa;
        r_xan  <= n_xan;
        r_xb   <= n_xb;
        r_xbn  <= n_xbn;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CNT_W'(OP_W-1)))
        else $error("divider step count overrun");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb - extended_euclid_gcd_unit testbench
// Sends directed and random operand pairs over the start/busy port and works
// out gcd and Bezout coefficients in a local model of the algorithm. Each
// o_valid beat is checked field by field against the oldest expected result.
// The sender idles in several phases.
// ---------------------------------------------------------------------------
module tb;
    import eeg_pkg::*;

    localparam int                N_RANDOM = 372;
    localparam logic [OP_W-1:0]   OP_MAX   = '1;
    localparam logic [OP_W-1:0]   FIB_46   = 31'd1836311903;
    localparam logic [OP_W-1:0]   FIB_45   = 31'd1134903170;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_eeg_in   beat_in = '0;
    logic      busy;
    logic      o_valid;
    t_eeg_out  o_result;

    t_eeg_in   pending_beats[$];
    t_eeg_out  expected_results[$];
    int        n_accepted = 0;
    int        n_errors   = 0;

    extended_euclid_gcd_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (beat_in),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // extended Euclid with coefficient arithmetic wrapping at 64 bits
    function automatic t_eeg_out bezout_of(t_eeg_in beat);
        logic [63:0] dvd, dvs, q, r, t;
        logic [63:0] xa, xa_n, xb, xb_n;
        t_eeg_out    res;
        dvd  = 64'(beat.operand_a);
        dvs  = 64'(beat.operand_b);
        xa   = 64'd1;
        xa_n = 64'd0;
        xb   = 64'd0;
        xb_n = 64'd1;
        while (dvs != 64'd0) begin
            q    = dvd / dvs;
            r    = dvd - q * dvs;
            dvd  = dvs;
            dvs  = r;
            t    = xa - q * xa_n;
            xa   = xa_n;
            xa_n = t;
            t    = xb - q * xb_n;
            xb   = xb_n;
            xb_n = t;
        end
        res.gcd_value = dvd[OP_W-1:0];
        res.coef_a    = xa[DATA_WIDTH-1:0];
        res.coef_b    = xb[DATA_WIDTH-1:0];
        return res;
    endfunction

    function automatic t_eeg_in operand_pair(logic [OP_W-1:0] a, logic [OP_W-1:0] b);
        t_eeg_in beat;
        beat.operand_a = a;
        beat.operand_b = b;
        return beat;
    endfunction

    function automatic void add_pending(t_eeg_in beat);
        pending_beats = {pending_beats, beat};
    endfunction

    function automatic logic [OP_W-1:0] any_operand();
        logic [31:0] raw;
        raw = $urandom;
        return raw[OP_W-1:0];
    endfunction

    function automatic t_eeg_in random_pair();
        logic [OP_W-1:0] a, b;
        a = any_operand();
        b = any_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4: begin
                a = OP_W'($urandom_range(1000));
                b = OP_W'($urandom_range(1000));
            end
            5: begin
                if ($urandom_range(1)) b = '0;
                else a = '0;
            end
            6: begin
                b = OP_W'($urandom_range(1, 65535));
                a = OP_W'(b * $urandom_range(0, 32767));
            end
            7: b = a - OP_W'($urandom_range(0, 255));
            8: b = a;
            default: begin
                a = a >> $urandom_range(30);
                b = b >> $urandom_range(30);
            end
        endcase
        return operand_pair(a, b);
    endfunction

    function automatic int idle_percent(int n);
        if (n < 130) return 0;
        if (n < 260) return 80;
        return 33;
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : drive
        logic take;
        take = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (take) begin
                expected_results = {expected_results, bezout_of(beat_in)};
                n_accepted <= n_accepted + 1;
            end
            if (take || !start) begin
                if (pending_beats.size() != 0 &&
                    $urandom_range(99) >= idle_percent(n_accepted)) begin
                    beat_in <= pending_beats.pop_front();
                    start   <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_eeg_out want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: gcd_value %0d", o_result.gcd_value);
                n_errors = n_errors + 1;
            end else begin
                want = expected_results.pop_front();
                if (o_result.gcd_value !== want.gcd_value) begin
                    $error("gcd_value: expected %0d, actual %0d",
                           want.gcd_value, o_result.gcd_value);
                    n_errors = n_errors + 1;
                end
                if (o_result.coef_a !== want.coef_a) begin
                    $error("coef_a: expected %0d, actual %0d", want.coef_a, o_result.coef_a);
                    n_errors = n_errors + 1;
                end
                if (o_result.coef_b !== want.coef_b) begin
                    $error("coef_b: expected %0d, actual %0d", want.coef_b, o_result.coef_b);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    initial begin
        add_pending(operand_pair('0, '0));
        add_pending(operand_pair(31'd12345, '0));
        add_pending(operand_pair('0, 31'd6789));
        add_pending(operand_pair(OP_MAX, '0));
        add_pending(operand_pair('0, OP_MAX));
        add_pending(operand_pair(OP_MAX, OP_MAX));
        add_pending(operand_pair(OP_MAX, 31'd1));
        add_pending(operand_pair(31'd1, OP_MAX));
        add_pending(operand_pair(OP_MAX, OP_MAX - 31'd1));
        add_pending(operand_pair(FIB_46, FIB_45));
        add_pending(operand_pair(FIB_45, FIB_46));
        add_pending(operand_pair(31'd1, 31'd1));
        add_pending(operand_pair(31'd240, 31'd46));
        add_pending(operand_pair(31'd46, 31'd240));
        add_pending(operand_pair(31'h4000_0000, 31'h2000_0000));
        add_pending(operand_pair(OP_MAX, 31'h4000_0000));
        add_pending(operand_pair(31'h5555_5555, 31'h2AAA_AAAA));
        add_pending(operand_pair(31'd2, OP_MAX));
        for (int i = 0; i < N_RANDOM; i++) add_pending(random_pair());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/eeg_pkg.sv
rtl/extended_euclid_gcd_unit.sv
tb/tb.sv
